/* rtl/glos_pkg.sv */
// Shared constants, codes and types for the grid line-of-sight wall check.
package glos_pkg;

    localparam int GRID_SIDE = 256;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COORD_W   = 8;
    localparam int FLAG_W    = 4;
    localparam int ERR_W     = COORD_W + 2;

    localparam logic [FLAG_W-1:0] EXIT_E = 4'b0001;
    localparam logic [FLAG_W-1:0] EXIT_W = 4'b0010;
    localparam logic [FLAG_W-1:0] EXIT_S = 4'b0100;
    localparam logic [FLAG_W-1:0] EXIT_N = 4'b1000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_RD_CUR,
        ST_RD_NXT,
        ST_CHK_NXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_query;
        logic write_cell;
        logic step;
        logic rd_cur;
        logic rd_nxt;
        logic move;
        logic set_blocked;
    } glos_cmd_t;

    typedef struct packed {
        logic  at_end;
        logic  pend_y;
        axis_t axis;
        logic  cur_open;
        logic  nxt_open;
    } glos_status_t;

endpackage

/* rtl/glos_ctrl.sv */
// Sequencer for cell loads and line walks: issues datapath commands per move.
module glos_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  operation,
    input  glos_pkg::glos_status_t status,
    output glos_pkg::glos_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import glos_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy       = (state_reg != ST_IDLE);
        done       = (state_reg == ST_DONE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_STEP;
                    end
                    else
                    begin
                        cmd.write_cell = 1'b1;
                    end
                end
            end
            ST_STEP:
            begin
                if (status.at_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_RD_CUR;
                end
            end
            ST_RD_CUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = ST_RD_NXT;
            end
            ST_RD_NXT:
            begin
                if (!status.cur_open)
                begin
                    cmd.set_blocked = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.rd_nxt = 1'b1;
                    state_next = ST_CHK_NXT;
                end
            end
            ST_CHK_NXT:
            begin
                if (!status.nxt_open)
                begin
                    cmd.set_blocked = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.move = 1'b1;
                    // diagonal step: y move follows the x move
                    if (status.axis == AXIS_X && status.pend_y)
                    begin
                        state_next = ST_RD_CUR;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/glos_dpath.sv */
// Cell memory, Bresenham stepping registers and wall checks.
module glos_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  glos_pkg::glos_cmd_t           cmd,
    input  logic [glos_pkg::COORD_W-1:0]  cell_x,
    input  logic [glos_pkg::COORD_W-1:0]  cell_y,
    input  logic [glos_pkg::FLAG_W-1:0]   cell_flags,
    input  logic [glos_pkg::COORD_W-1:0]  start_x,
    input  logic [glos_pkg::COORD_W-1:0]  start_y,
    input  logic [glos_pkg::COORD_W-1:0]  end_x,
    input  logic [glos_pkg::COORD_W-1:0]  end_y,
    output glos_pkg::glos_status_t        status,
    output logic                          blocked
);
    import glos_pkg::*;

    function automatic logic in_grid(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        in_grid = (int'(x) < GRID_SIDE) && (int'(y) < GRID_SIDE);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        cell_addr = ADDR_W'(int'(x) * GRID_SIDE + int'(y));
    endfunction

    logic [FLAG_W-1:0]  mem [CELLS];
    logic [FLAG_W-1:0]  rdata_reg;
    logic               rok_reg;

    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;
    logic [COORD_W-1:0] x1_reg;
    logic [COORD_W-1:0] y1_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic               sx_neg_reg;
    logic               sy_neg_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic               pend_y_reg;
    axis_t              axis_reg;
    logic               blocked_reg;

    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] rd_x;
    logic [COORD_W-1:0] rd_y;
    logic [COORD_W-1:0] dx_in;
    logic [COORD_W-1:0] dy_in;
    logic signed [ERR_W:0]   e2;
    logic signed [ERR_W:0]   dx_s;
    logic signed [ERR_W:0]   dy_s;
    logic               do_x;
    logic               do_y;
    logic signed [ERR_W-1:0] err_upd;
    logic [FLAG_W-1:0]  cell_val;
    logic [FLAG_W-1:0]  side;
    logic [FLAG_W-1:0]  opp;
    logic               rd_en;

    assign nx = (axis_reg == AXIS_X) ? (sx_neg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1) : cx_reg;
    assign ny = (axis_reg == AXIS_Y) ? (sy_neg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1) : cy_reg;

    assign rd_en = cmd.rd_cur | cmd.rd_nxt;
    assign rd_x  = cmd.rd_nxt ? nx : cx_reg;
    assign rd_y  = cmd.rd_nxt ? ny : cy_reg;

    assign dx_in = (end_x > start_x) ? end_x - start_x : start_x - end_x;
    assign dy_in = (end_y > start_y) ? end_y - start_y : start_y - end_y;

    assign e2   = {err_reg, 1'b0};
    assign dx_s = $signed({3'b000, dx_reg});
    assign dy_s = $signed({3'b000, dy_reg});
    assign do_x = e2 > -dy_s;
    assign do_y = e2 < dx_s;
    assign err_upd = err_reg
                   - (do_x ? $signed({2'b00, dy_reg}) : $signed(ERR_W'(0)))
                   + (do_y ? $signed({2'b00, dx_reg}) : $signed(ERR_W'(0)));

    assign cell_val = rok_reg ? rdata_reg : '0;

    always_comb
    begin
        if (axis_reg == AXIS_X)
        begin
            side = sx_neg_reg ? EXIT_W : EXIT_E;
            opp  = sx_neg_reg ? EXIT_E : EXIT_W;
        end
        else
        begin
            side = sy_neg_reg ? EXIT_S : EXIT_N;
            opp  = sy_neg_reg ? EXIT_N : EXIT_S;
        end
    end

    assign status.at_end   = (cx_reg == x1_reg) && (cy_reg == y1_reg);
    assign status.pend_y   = pend_y_reg;
    assign status.axis     = axis_reg;
    assign status.cur_open = |(cell_val & side);
    assign status.nxt_open = |(cell_val & opp);
    assign blocked         = blocked_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_cell && in_grid(cell_x, cell_y))
        begin
            mem[cell_addr(cell_x, cell_y)] <= cell_flags;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[cell_addr(rd_x, rd_y)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rok_reg <= in_grid(rd_x, rd_y);
        end
        if (cmd.load_query)
        begin
            cx_reg     <= start_x;
            cy_reg     <= start_y;
            x1_reg     <= end_x;
            y1_reg     <= end_y;
            dx_reg     <= dx_in;
            dy_reg     <= dy_in;
            sx_neg_reg <= !(start_x < end_x);
            sy_neg_reg <= !(start_y < end_y);
            err_reg    <= $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});
        end
        else if (cmd.step)
        begin
            err_reg <= err_upd;
        end
        else if (cmd.move)
        begin
            cx_reg <= nx;
            cy_reg <= ny;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_y_reg  <= 1'b0;
            axis_reg    <= AXIS_X;
            blocked_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_query)
            begin
                blocked_reg <= 1'b0;
            end
            else if (cmd.set_blocked)
            begin
                blocked_reg <= 1'b1;
            end
            if (cmd.step)
            begin
                pend_y_reg <= do_y;
                axis_reg   <= do_x ? AXIS_X : AXIS_Y;
            end
            else if (cmd.move)
            begin
                if (axis_reg == AXIS_X)
                begin
                    axis_reg <= AXIS_Y;
                end
                else
                begin
                    pend_y_reg <= 1'b0;
                end
            end
        end
    end

endmodule

/* rtl/grid_line_of_sight_wall_check_core.sv */
// Top level of the grid line-of-sight wall check: controller plus datapath.
// A load (operation 0) writes one cell in the cycle it is accepted, leaves busy low and
// gives no result. A query (operation 1) walks the Bresenham line and raises done for one
// cycle with blocked valid; the result cannot be held off, so it must be taken in that
// cycle. A query walks until the end point or until a wall ends it early; each move passes
// through ST_RD_CUR, ST_RD_NXT and ST_CHK_NXT on the single read port of the cell memory
// (current cell, then the neighbor). Cells must be loaded before a query reads them; the
// memory has no reset.
module grid_line_of_sight_wall_check_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [glos_pkg::COORD_W-1:0]  cell_x,
    input  logic [glos_pkg::COORD_W-1:0]  cell_y,
    input  logic [glos_pkg::FLAG_W-1:0]   cell_flags,
    input  logic [glos_pkg::COORD_W-1:0]  start_x,
    input  logic [glos_pkg::COORD_W-1:0]  start_y,
    input  logic [glos_pkg::COORD_W-1:0]  end_x,
    input  logic [glos_pkg::COORD_W-1:0]  end_y,
    output logic                          done,
    output logic                          blocked
);
    import glos_pkg::*;

    glos_cmd_t    cmd;
    glos_status_t status;

    glos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    glos_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_flags (cell_flags),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .status     (status),
        .blocked    (blocked)
    );

endmodule

/* verif/grid_line_of_sight_wall_check_core_tb.sv */
// Testbench for the grid line-of-sight wall check core: line-walk scoreboard and stimulus.
`timescale 1ns / 1ps

module grid_line_of_sight_wall_check_core_tb;
    import glos_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int TAIL_CYCLES    = 20;
    localparam int ITEM_TARGET    = 580;
    localparam int QUIET_FROM     = 520;
    localparam int MAX_COORD      = GRID_SIDE - 1;
    localparam logic [FLAG_W-1:0] ALL_OPEN = 4'hF;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [FLAG_W-1:0]  flags_t;

    typedef struct {
        bit     blocked;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } answer_t;

    class los_scoreboard;
        flags_t  cell_mem [0:CELLS-1];
        bit      loaded [0:CELLS-1];
        answer_t pending_answers [$];
        int      line_cells [$];
        int      mismatches;

        function new();
            foreach (cell_mem[i])
            begin
                cell_mem[i] = '0;
                loaded[i]   = 1'b0;
            end
            mismatches = 0;
        endfunction

        function void add_line_cell(int idx);
            line_cells.insert(line_cells.size(), idx);
        endfunction

        function void queue_answer(answer_t a);
            pending_answers.insert(pending_answers.size(), a);
        endfunction

        function bit move_walled(int fx, int fy, int tx, int ty, flags_t out_side,
                                 flags_t in_side);
            return ((cell_mem[fx * GRID_SIDE + fy] & out_side) == '0) ||
                   ((cell_mem[tx * GRID_SIDE + ty] & in_side) == '0);
        endfunction

        // Walks the whole line, collecting every cell visited; x move before y move.
        function bit trace_line(int x0, int y0, int x1, int y1);
            int dx, dy, sx, sy, err, e2, cx, cy, n;
            bit hit;
            dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx  = (x0 < x1) ? 1 : -1;
            sy  = (y0 < y1) ? 1 : -1;
            err = dx - dy;
            cx  = x0;
            cy  = y0;
            hit = 1'b0;
            line_cells.delete();
            add_line_cell(cx * GRID_SIDE + cy);
            for (n = 0; n < dx + dy + 1 && (cx != x1 || cy != y1); n++)
            begin
                e2 = 2 * err;
                if (e2 > -dy)
                begin
                    err -= dy;
                    hit |= move_walled(cx, cy, cx + sx, cy,
                                       (sx > 0) ? EXIT_E : EXIT_W, (sx > 0) ? EXIT_W : EXIT_E);
                    cx += sx;
                    add_line_cell(cx * GRID_SIDE + cy);
                end
                if (e2 < dx)
                begin
                    err += dx;
                    hit |= move_walled(cx, cy, cx, cy + sy,
                                       (sy > 0) ? EXIT_N : EXIT_S, (sy > 0) ? EXIT_S : EXIT_N);
                    cy += sy;
                    add_line_cell(cx * GRID_SIDE + cy);
                end
            end
            return hit;
        endfunction

        function void note_item(op_t op, coord_t cx, coord_t cy, flags_t flags,
                                coord_t x0, coord_t y0, coord_t x1, coord_t y1);
            answer_t a;
            if (op == OP_LOAD)
            begin
                cell_mem[cx * GRID_SIDE + cy] = flags;
                loaded[cx * GRID_SIDE + cy]   = 1'b1;
            end
            else
            begin
                a.blocked = trace_line(x0, y0, x1, y1);
                a.x0 = x0;
                a.y0 = y0;
                a.x1 = x1;
                a.y1 = y1;
                queue_answer(a);
            end
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic got);
            answer_t a;
            if (pending_answers.size() == 0)
                report_mismatch("result with no query pending");
            else
            begin
                a = pending_answers.pop_front();
                if (got !== a.blocked)
                    report_mismatch($sformatf("line (%0d,%0d)->(%0d,%0d) blocked %b, want %b",
                                              a.x0, a.y0, a.x1, a.y1, got, a.blocked));
            end
        endtask
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   operation = 1'b0;
    coord_t cell_x = '0;
    coord_t cell_y = '0;
    flags_t cell_flags = '0;
    coord_t start_x = '0;
    coord_t start_y = '0;
    coord_t end_x = '0;
    coord_t end_y = '0;
    logic   busy;
    logic   done;
    logic   blocked;

    los_scoreboard sb = new();
    int items_sent = 0;
    int idle_cycles = 0;

    grid_line_of_sight_wall_check_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_flags (cell_flags),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .done       (done),
        .blocked    (blocked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n && done)
            sb.check_result(blocked);
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("grid_line_of_sight_wall_check_core test failed");
                $finish;
            end
        end
    end

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(op_t op, coord_t cx, coord_t cy, flags_t flags,
                             coord_t x0, coord_t y0, coord_t x1, coord_t y1);
        if (items_sent < QUIET_FROM && ((items_sent / 40) % 3) != 0 &&
            $urandom_range(0, 3) == 0)
            pause($urandom_range(1, 11));
        start      <= 1'b1;
        operation  <= op;
        cell_x     <= cx;
        cell_y     <= cy;
        cell_flags <= flags;
        start_x    <= x0;
        start_y    <= y0;
        end_x      <= x1;
        end_y      <= y1;
        do
            @(negedge clk);
        while (busy);
        sb.note_item(op, cx, cy, flags, x0, y0, x1, y1);
        items_sent++;
        @(posedge clk);
    endtask

    task automatic load_cell(int x, int y, flags_t flags);
        send_item(OP_LOAD, coord_t'(x), coord_t'(y), flags,
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
    endtask

    task automatic query(int x0, int y0, int x1, int y1);
        send_item(OP_QUERY, coord_t'($urandom), coord_t'($urandom), flags_t'($urandom),
                  coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1));
    endtask

    // Loads the cells a query on this line will read; fresh reloads every one.
    task automatic prepare_line(int x0, int y0, int x1, int y1, bit fresh, bit all_open);
        int     path [$];
        flags_t f;
        void'(sb.trace_line(x0, y0, x1, y1));
        path = sb.line_cells;
        foreach (path[i])
        begin
            if (fresh || !sb.loaded[path[i]])
            begin
                f = (all_open || $urandom_range(0, 3) != 0) ? ALL_OPEN
                                                           : flags_t'($urandom_range(0, 15));
                load_cell(path[i] / GRID_SIDE, path[i] % GRID_SIDE, f);
            end
        end
    endtask

    task automatic wall_case(int x0, int y0, int x1, int y1, int wx, int wy, flags_t wf);
        prepare_line(x0, y0, x1, y1, 1'b1, 1'b1);
        load_cell(wx, wy, wf);
        query(x0, y0, x1, y1);
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    initial
    begin
        int x0, y0, x1, y1, span;
        bit mid_drained;
        mid_drained = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // same start and end, even on a cell with no exits
        query(0, 0, 0, 0);
        load_cell(MAX_COORD, MAX_COORD, 4'h0);
        query(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);

        // clear lines at the grid corners
        prepare_line(0, 0, 5, 3, 1'b1, 1'b1);
        query(0, 0, 5, 3);
        prepare_line(MAX_COORD, MAX_COORD, MAX_COORD - 5, MAX_COORD - 3, 1'b1, 1'b1);
        query(MAX_COORD, MAX_COORD, MAX_COORD - 5, MAX_COORD - 3);
        prepare_line(0, MAX_COORD, 3, MAX_COORD - 5, 1'b1, 1'b1);
        query(0, MAX_COORD, 3, MAX_COORD - 5);
        prepare_line(MAX_COORD, 0, MAX_COORD - 6, 2, 1'b1, 1'b1);
        query(MAX_COORD, 0, MAX_COORD - 6, 2);

        // exit and entry walls in each direction
        wall_case(10, 10, 14, 10, 12, 10, ALL_OPEN & ~EXIT_E);
        wall_case(10, 10, 14, 10, 13, 10, ALL_OPEN & ~EXIT_W);
        wall_case(14, 12, 10, 12, 12, 12, ALL_OPEN & ~EXIT_W);
        wall_case(14, 12, 10, 12, 11, 12, ALL_OPEN & ~EXIT_E);
        wall_case(30, 5, 30, 9, 30, 7, ALL_OPEN & ~EXIT_N);
        wall_case(30, 5, 30, 9, 30, 8, ALL_OPEN & ~EXIT_S);
        wall_case(32, 9, 32, 5, 32, 7, ALL_OPEN & ~EXIT_S);
        wall_case(32, 9, 32, 5, 32, 6, ALL_OPEN & ~EXIT_N);

        // diagonal step: x move first, then y move from the cell reached
        wall_case(20, 20, 21, 21, 20, 20, ALL_OPEN & ~EXIT_N);
        wall_case(20, 20, 21, 21, 21, 20, ALL_OPEN & ~EXIT_N);
        wall_case(40, 40, 39, 39, 39, 40, ALL_OPEN & ~EXIT_S);

        drain();

        while (items_sent < ITEM_TARGET)
        begin
            if (!mid_drained && items_sent >= ITEM_TARGET / 2)
            begin
                drain();
                mid_drained = 1'b1;
            end
            if ($urandom_range(0, 9) < 2)
                send_item(OP_LOAD, coord_t'($urandom), coord_t'($urandom), flags_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom));
            else
            begin
                span = ($urandom_range(0, 15) == 0) ? 40 : 6;
                x0 = $urandom_range(0, MAX_COORD);
                y0 = $urandom_range(0, MAX_COORD);
                x1 = clamp_coord(x0 + $urandom_range(0, 2 * span) - span);
                y1 = clamp_coord(y0 + $urandom_range(0, 2 * span) - span);
                prepare_line(x0, y0, x1, y1, $urandom_range(0, 2) == 0, 1'b0);
                query(x0, y0, x1, y1);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending_answers.size() != 0)
            sb.report_mismatch("queries left without a result");
        if (sb.mismatches == 0)
            $display("grid_line_of_sight_wall_check_core test passed");
        else
            $display("grid_line_of_sight_wall_check_core test failed");
        $finish;
    end

endmodule
